/* rtl/core/hvn_pkg.sv */
// Shared types and constants for the heightfield vertex normal generator.
package hvn_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [1:0] CFG_GRID_DEPTH = 2'd1;

    localparam logic [8:0] CFG_DIM_RESET = 9'd256;
    localparam logic [8:0] CFG_DIM_MIN   = 9'd2;

    // Vertical code step of a triangle normal (one unit of height is ten codes)
    localparam logic [15:0] HEIGHT_UNIT = 16'd10;

    localparam logic [30:0] HEIGHT_UNIT_SQ = 31'd100;

    // Quotient limits of the two scaling passes
    localparam logic [14:0] TRI_QMAX = 15'd4096;
    localparam logic [3:0]  TRI_TOP_BIT = 4'd12;
    localparam logic [3:0]  OUT_TOP_BIT = 4'd14;

    localparam logic [2:0] LAST_TRI = 3'd7;
    localparam logic [3:0] NUM_TAPS = 4'd9;

    typedef enum logic [2:0] {
        NU_IDLE,
        NU_SQ,
        NU_CAND,
        NU_MUL1,
        NU_MUL2,
        NU_CMP
    } t_nu_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TRI,
        ST_TLEN,
        ST_SCALE,
        ST_WAIT,
        ST_FLEN,
        ST_DONE
    } t_ctl_state;

    // Request to the scaling unit: round(mag * 2^fb / sqrt(len2))
    typedef struct packed {
        logic        start;
        logic        fine;   // 1: Q1.15 output pass, 0: Q1.12 triangle pass
        logic [15:0] mag;
        logic [30:0] len2;
    } t_nu_req;

    typedef struct packed {
        logic        done;
        logic [14:0] q;
    } t_nu_rsp;

endpackage

/* rtl/core/hvn_height_mem.sv */
// Single-port height sample memory with registered read data.
module hvn_height_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/hvn_norm_unit.sv */
// Bit-serial scaling unit: nearest integer to mag * 2^fb / sqrt(len2).
module hvn_norm_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hvn_pkg::t_nu_req i_req,
    output hvn_pkg::t_nu_rsp o_rsp
);

    hvn_pkg::t_nu_state r_state, n_state;

    logic        r_fine;
    logic [15:0] r_mag;
    logic [30:0] r_len2;
    logic [63:0] r_rhs;
    logic [14:0] r_q;
    logic [14:0] r_cand;
    logic        r_over;
    logic [15:0] r_t;
    logic [31:0] r_sq;
    logic [62:0] r_prod;
    logic [3:0]  r_bit;
    logic        r_done;

    logic [31:0] mag2;
    logic [14:0] cand;

    assign mag2 = r_mag * r_mag;
    assign cand = r_q | (15'd1 << r_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hvn_pkg::NU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hvn_pkg::NU_IDLE: if (i_req.start) n_state = hvn_pkg::NU_SQ;
            hvn_pkg::NU_SQ:   n_state = hvn_pkg::NU_CAND;
            hvn_pkg::NU_CAND: n_state = hvn_pkg::NU_MUL1;
            hvn_pkg::NU_MUL1: n_state = hvn_pkg::NU_MUL2;
            hvn_pkg::NU_MUL2: n_state = hvn_pkg::NU_CMP;
            hvn_pkg::NU_CMP: begin
                n_state = (r_bit == 4'd0) ? hvn_pkg::NU_IDLE : hvn_pkg::NU_CAND;
            end
            default: n_state = hvn_pkg::NU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == hvn_pkg::NU_CMP) && (r_bit == 4'd0);
        end
    end

    // Largest q with (2q-1)^2 * len2 <= mag^2 * 2^(2fb+2), found MSB first
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hvn_pkg::NU_IDLE: begin
                if (i_req.start) begin
                    r_fine <= i_req.fine;
                    r_mag  <= i_req.mag;
                    r_len2 <= i_req.len2;
                end
            end
            hvn_pkg::NU_SQ: begin
                r_rhs <= r_fine ? {mag2, 32'd0} : {6'd0, mag2, 26'd0};
                r_q   <= '0;
                r_bit <= r_fine ? hvn_pkg::OUT_TOP_BIT : hvn_pkg::TRI_TOP_BIT;
            end
            hvn_pkg::NU_CAND: begin
                r_cand <= cand;
                r_t    <= {cand, 1'b0} - 16'd1;
                r_over <= !r_fine && (cand > hvn_pkg::TRI_QMAX);
            end
            hvn_pkg::NU_MUL1: r_sq <= r_t * r_t;
            hvn_pkg::NU_MUL2: r_prod <= 63'(r_sq * r_len2);
            hvn_pkg::NU_CMP: begin
                if (!r_over && ({1'b0, r_prod} <= r_rhs)) begin
                    r_q <= r_cand;
                end
                if (r_bit != 4'd0) begin
                    r_bit <= r_bit - 4'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

/* rtl/core/heightfield_vertex_normal_gen.sv */
// Heightfield vertex normal generator top level: sample store, query sequencer, output register.
//
// A write transaction is taken in the idle state, and an out-of-grid query goes straight to the
// done state. An in-grid query reads its 3x3 neighborhood from the single-port sample memory,
// then scales each of the up to six triangle normals and finally the summed normal through one
// bit-serial scaling unit, which settles each quotient bit in candidate, square, multiply and
// compare steps (13 bits per triangle component, 15 per output component). The next transaction
// is taken once the previous one is done, even while its result still waits in the output
// register.
module heightfield_vertex_normal_gen #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_col,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_height_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_normal_x,
    output logic [14:0] o_normal_y,
    output logic [15:0] o_normal_z,
    output logic        o_status
);

    localparam int DEPTH = MAX_WIDTH * MAX_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXD  = (MAX_WIDTH > MAX_DEPTH) ? MAX_WIDTH : MAX_DEPTH;
    localparam int DW    = ($clog2(MAXD + 1) > 9) ? $clog2(MAXD + 1) : 9;

    hvn_pkg::t_ctl_state r_state, n_state;

    logic [8:0]  r_cfg_width;
    logic [8:0]  r_cfg_depth;
    logic [DW-1:0] w_eff, d_eff;

    logic [7:0]  r_col, r_row;
    logic        r_top_ok, r_bot_ok, r_left_ok, r_right_ok;
    logic [3:0]  r_cnt;
    logic [7:0]  r_h [9];
    logic [2:0]  r_tri;
    logic [1:0]  r_step;
    logic [1:0]  r_comp;
    logic        r_final;
    logic signed [8:0]  r_dx, r_dz;
    logic [30:0] r_len2;
    logic signed [15:0] r_acc [3];
    logic signed [15:0] r_res [3];
    logic        r_stat;

    logic        r_out_valid;
    logic [15:0] r_out_x, r_out_z;
    logic [14:0] r_out_y;
    logic        r_out_stat;

    logic        in_fire, out_load;
    logic        oog;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]  mem_rdata;
    logic [1:0]  tap_y, tap_x;
    logic        tap_ok;
    logic [7:0]  tap_r, tap_c;
    logic signed [8:0] tri_dx [8];
    logic signed [8:0] tri_dz [8];
    logic [7:0]  tri_ok;
    logic signed [15:0] sq_in;
    logic signed [31:0] sq_out;
    logic [15:0] sc_mag;
    logic        sc_neg;
    logic signed [15:0] q_signed;

    hvn_pkg::t_nu_req nu_req;
    hvn_pkg::t_nu_rsp nu_rsp;

    // Effective grid size, registers clamped to [2, MAX]
    always_comb begin
        if (r_cfg_width < hvn_pkg::CFG_DIM_MIN) begin
            w_eff = DW'(hvn_pkg::CFG_DIM_MIN);
        end else if (DW'(r_cfg_width) > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(r_cfg_width);
        end
        if (r_cfg_depth < hvn_pkg::CFG_DIM_MIN) begin
            d_eff = DW'(hvn_pkg::CFG_DIM_MIN);
        end else if (DW'(r_cfg_depth) > DW'(MAX_DEPTH)) begin
            d_eff = DW'(MAX_DEPTH);
        end else begin
            d_eff = DW'(r_cfg_depth);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= hvn_pkg::CFG_DIM_RESET;
            r_cfg_depth <= hvn_pkg::CFG_DIM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == hvn_pkg::CFG_GRID_WIDTH) r_cfg_width <= i_cfg_data;
            if (i_cfg_index == hvn_pkg::CFG_GRID_DEPTH) r_cfg_depth <= i_cfg_data;
        end
    end

    assign o_in_ready = (r_state == hvn_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign oog        = (DW'(i_col) >= w_eff) || (DW'(i_row) >= d_eff);
    assign out_load   = (r_state == hvn_pkg::ST_DONE) && (!r_out_valid || i_out_ready);

    // Neighborhood tap k sits at row offset k/3 - 1 and column offset k%3 - 1
    always_comb begin
        unique case (r_cnt)
            4'd0: begin tap_y = 2'd0; tap_x = 2'd0; end
            4'd1: begin tap_y = 2'd0; tap_x = 2'd1; end
            4'd2: begin tap_y = 2'd0; tap_x = 2'd2; end
            4'd3: begin tap_y = 2'd1; tap_x = 2'd0; end
            4'd4: begin tap_y = 2'd1; tap_x = 2'd1; end
            4'd5: begin tap_y = 2'd1; tap_x = 2'd2; end
            4'd6: begin tap_y = 2'd2; tap_x = 2'd0; end
            4'd7: begin tap_y = 2'd2; tap_x = 2'd1; end
            4'd8: begin tap_y = 2'd2; tap_x = 2'd2; end
            default: begin tap_y = 2'd1; tap_x = 2'd1; end
        endcase
        tap_ok = (tap_y != 2'd0 || r_top_ok) && (tap_y != 2'd2 || r_bot_ok) &&
                 (tap_x != 2'd0 || r_left_ok) && (tap_x != 2'd2 || r_right_ok);
        tap_r  = r_row + 8'(tap_y) - 8'd1;
        tap_c  = r_col + 8'(tap_x) - 8'd1;
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = '0;
        if (r_state == hvn_pkg::ST_IDLE) begin
            mem_we   = in_fire && !i_mode && (32'(i_col) < 32'(MAX_WIDTH)) &&
                       (32'(i_row) < 32'(MAX_DEPTH));
            mem_addr = AW'(32'(i_row) * 32'(MAX_WIDTH) + 32'(i_col));
        end else if (tap_ok) begin
            mem_addr = AW'(32'(tap_r) * 32'(MAX_WIDTH) + 32'(tap_c));
        end
    end

    hvn_height_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_height_code),
        .o_rdata (mem_rdata)
    );

    // Cell c covers taps rows c>>1..+1, cols c&1..+1; triangle 2c is a-b-c, 2c+1 is a-c-d
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            tri_dx[2*c]   = $signed({1'b0, r_h[((c >> 1) + 1) * 3 + (c & 1)]}) -
                            $signed({1'b0, r_h[((c >> 1) + 1) * 3 + (c & 1) + 1]});
            tri_dz[2*c]   = $signed({1'b0, r_h[(c >> 1) * 3 + (c & 1) + 1]}) -
                            $signed({1'b0, r_h[((c >> 1) + 1) * 3 + (c & 1) + 1]});
            tri_dx[2*c+1] = $signed({1'b0, r_h[(c >> 1) * 3 + (c & 1)]}) -
                            $signed({1'b0, r_h[(c >> 1) * 3 + (c & 1) + 1]});
            tri_dz[2*c+1] = $signed({1'b0, r_h[(c >> 1) * 3 + (c & 1)]}) -
                            $signed({1'b0, r_h[((c >> 1) + 1) * 3 + (c & 1)]});
        end
        // Cell validity; in the two diagonal cells the triangle that does not touch the vertex is skipped
        tri_ok[0] = r_top_ok && r_left_ok;
        tri_ok[1] = 1'b0;
        tri_ok[2] = r_top_ok && r_right_ok;
        tri_ok[3] = r_top_ok && r_right_ok;
        tri_ok[4] = r_bot_ok && r_left_ok;
        tri_ok[5] = r_bot_ok && r_left_ok;
        tri_ok[6] = 1'b0;
        tri_ok[7] = r_bot_ok && r_right_ok;
    end

    // Shared squarer for triangle and final lengths
    always_comb begin
        if (r_state == hvn_pkg::ST_FLEN) begin
            sq_in = r_acc[r_step];
        end else if (r_step == 2'd0) begin
            sq_in = 16'(r_dx);
        end else begin
            sq_in = 16'(r_dz);
        end
        sq_out = sq_in * sq_in;
    end

    always_comb begin
        logic signed [15:0] v;
        if (r_final) begin
            v = r_acc[r_comp];
        end else if (r_comp == 2'd0) begin
            v = 16'(r_dx);
        end else if (r_comp == 2'd1) begin
            v = $signed(hvn_pkg::HEIGHT_UNIT);
        end else begin
            v = 16'(r_dz);
        end
        sc_neg = v[15];
        sc_mag = sc_neg ? 16'(-v) : 16'(v);
    end

    assign nu_req.start = (r_state == hvn_pkg::ST_SCALE);
    assign nu_req.fine  = r_final;
    assign nu_req.mag   = sc_mag;
    assign nu_req.len2  = r_len2;
    assign q_signed     = sc_neg ? -$signed({1'b0, nu_rsp.q}) : $signed({1'b0, nu_rsp.q});

    hvn_norm_unit u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (nu_req),
        .o_rsp   (nu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hvn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hvn_pkg::ST_IDLE: begin
                if (in_fire && i_mode) begin
                    n_state = oog ? hvn_pkg::ST_DONE : hvn_pkg::ST_READ;
                end
            end
            hvn_pkg::ST_READ: if (r_cnt == hvn_pkg::NUM_TAPS) n_state = hvn_pkg::ST_TRI;
            hvn_pkg::ST_TRI: begin
                if (tri_ok[r_tri]) begin
                    n_state = hvn_pkg::ST_TLEN;
                end else if (r_tri == hvn_pkg::LAST_TRI) begin
                    n_state = hvn_pkg::ST_FLEN;
                end
            end
            hvn_pkg::ST_TLEN: if (r_step == 2'd1) n_state = hvn_pkg::ST_SCALE;
            hvn_pkg::ST_SCALE: n_state = hvn_pkg::ST_WAIT;
            hvn_pkg::ST_WAIT: begin
                if (nu_rsp.done) begin
                    if (r_comp != 2'd2) begin
                        n_state = hvn_pkg::ST_SCALE;
                    end else if (r_final) begin
                        n_state = hvn_pkg::ST_DONE;
                    end else if (r_tri == hvn_pkg::LAST_TRI) begin
                        n_state = hvn_pkg::ST_FLEN;
                    end else begin
                        n_state = hvn_pkg::ST_TRI;
                    end
                end
            end
            hvn_pkg::ST_FLEN: if (r_step == 2'd2) n_state = hvn_pkg::ST_SCALE;
            hvn_pkg::ST_DONE: if (out_load) n_state = hvn_pkg::ST_IDLE;
            default: n_state = hvn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hvn_pkg::ST_IDLE: begin
                r_col      <= i_col;
                r_row      <= i_row;
                r_top_ok   <= (i_row != 8'd0);
                r_left_ok  <= (i_col != 8'd0);
                r_bot_ok   <= (DW'(i_row) + DW'(1) < d_eff);
                r_right_ok <= (DW'(i_col) + DW'(1) < w_eff);
                r_cnt      <= '0;
                r_final    <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_acc[k] <= '0;
                    r_res[k] <= '0;
                end
                r_stat     <= oog;
            end
            hvn_pkg::ST_READ: begin
                if (r_cnt != 4'd0) r_h[r_cnt - 4'd1] <= mem_rdata;
                r_cnt <= r_cnt + 4'd1;
                r_tri <= '0;
            end
            hvn_pkg::ST_TRI: begin
                r_dx   <= tri_dx[r_tri];
                r_dz   <= tri_dz[r_tri];
                r_step <= '0;
                if (!tri_ok[r_tri] && r_tri != hvn_pkg::LAST_TRI) r_tri <= r_tri + 3'd1;
            end
            hvn_pkg::ST_TLEN: begin
                if (r_step == 2'd0) begin
                    r_len2 <= 31'(sq_out) + hvn_pkg::HEIGHT_UNIT_SQ;
                end else begin
                    r_len2 <= r_len2 + 31'(sq_out);
                end
                r_step <= r_step + 2'd1;
                r_comp <= '0;
            end
            hvn_pkg::ST_SCALE: ;
            hvn_pkg::ST_WAIT: begin
                if (nu_rsp.done) begin
                    if (r_final) begin
                        r_res[r_comp] <= q_signed;
                    end else begin
                        r_acc[r_comp] <= r_acc[r_comp] + q_signed;
                    end
                    r_comp <= r_comp + 2'd1;
                    r_step <= '0;
                    if (r_comp == 2'd2 && !r_final && r_tri != hvn_pkg::LAST_TRI) begin
                        r_tri <= r_tri + 3'd1;
                    end
                end
            end
            hvn_pkg::ST_FLEN: begin
                r_len2  <= ((r_step == 2'd0) ? 31'd0 : r_len2) + 31'(sq_out);
                r_step  <= r_step + 2'd1;
                r_comp  <= '0;
                r_final <= 1'b1;
            end
            hvn_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // Output register: the sequencer may start the next transaction while this waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x    <= r_res[0];
            r_out_y    <= r_res[1][14:0];
            r_out_z    <= r_res[2];
            r_out_stat <= r_stat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_normal_x  = r_out_x;
    assign o_normal_y  = r_out_y;
    assign o_normal_z  = r_out_z;
    assign o_status    = r_out_stat;

    a_done_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nu_rsp.done |-> (r_state == hvn_pkg::ST_WAIT))
        else $error("scaling unit finished outside the wait state");

    a_error_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |->
        (o_normal_x == 16'd0 && o_normal_y == 15'd0 && o_normal_z == 16'd0))
        else $error("out-of-grid result carries a nonzero normal");

    a_ok_result_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |-> (o_normal_y != 15'd0))
        else $error("in-grid normal has no vertical component");

    a_load_frees_sequencer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_state == hvn_pkg::ST_IDLE))
        else $error("result load did not return the sequencer to idle");

endmodule
